### rtl/core/mvdr_pkg.sv
// Shared types, widths and codes of the matrix-vector row product block.
package mvdr_pkg;

    localparam int VAL_W     = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int SUM_W     = 32;
    localparam int GRP_W     = 8;
    localparam int RL_W      = 11;
    localparam int RC_W      = 16;
    localparam int IN_LANES  = 4;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_ROW_COUNT  = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [GRP_W-1:0]        group_index;
        logic signed [VAL_W-1:0] lane_value_0;
        logic signed [VAL_W-1:0] lane_value_1;
        logic signed [VAL_W-1:0] lane_value_2;
        logic signed [VAL_W-1:0] lane_value_3;
    } t_in_beat;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic                    saturated;
        logic                    last_row;
    } t_out_beat;

    // Per-group control that follows the lane products down the pipe.
    typedef struct packed {
        logic valid;
        logic end_row;
        logic last_row;
    } t_grp_ctl;

    // Stage enables handed to every lane.
    typedef struct packed {
        logic cap;
        logic mul;
    } t_lane_ctl;

    // Pick one lane field of an input beat.
    function automatic logic signed [VAL_W-1:0] lane_field(input t_in_beat b,
                                                           input logic [1:0] idx);
        logic signed [VAL_W-1:0] v;
        unique case (idx)
            2'd0:    v = b.lane_value_0;
            2'd1:    v = b.lane_value_1;
            2'd2:    v = b.lane_value_2;
            default: v = b.lane_value_3;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/mvdr_lane.sv
// One lane: a bank of the vector store and one registered multiplier.
module mvdr_lane #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                 i_clk,
    input  mvdr_pkg::t_lane_ctl                  i_ctl,
    input  logic                                 i_wr_en,
    input  logic [AW-1:0]                        i_wr_addr,
    input  logic signed [mvdr_pkg::VAL_W-1:0]    i_wr_data,
    input  logic [AW-1:0]                        i_rd_addr,
    input  logic signed [mvdr_pkg::VAL_W-1:0]    i_mat,
    input  logic                                 i_use,
    output logic signed [mvdr_pkg::PROD_W-1:0]   o_prod
);

    logic signed [mvdr_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic signed [mvdr_pkg::VAL_W-1:0] r_vec;
    logic signed [mvdr_pkg::VAL_W-1:0] r_mat;
    logic                              r_use;
    logic signed [mvdr_pkg::PROD_W-1:0] r_prod;

    // Write load beats into the bank.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the vector element and hold the matrix element beside it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_vec <= r_mem[i_rd_addr];
            r_mat <= i_mat;
            r_use <= i_use;
        end
    end

    // Multiply; drop lanes past the row end.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            if (r_use) begin
                r_prod <= r_mat * r_vec;
            end else begin
                r_prod <= '0;
            end
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/mvdr_merge.sv
// Merge stage: lane sum, row accumulator, scaling, saturation and output register.
module mvdr_merge #(
    parameter int LANES     = 4,
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [mvdr_pkg::PROD_W-1:0]  i_prod [LANES],
    input  mvdr_pkg::t_grp_ctl                  i_grp,
    output logic                                o_take,
    output logic                                o_out_valid,
    output mvdr_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_out_ready
);

    localparam int AW = mvdr_pkg::ACC_W;
    localparam logic signed [AW-1:0] SUM_MAX = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] SUM_MIN = AW'(-64'sd2147483648);

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] r_row;
    logic                 r_row_valid;
    logic                 r_row_last;
    logic                 r_out_valid;
    mvdr_pkg::t_out_beat  r_out_beat;

    logic signed [AW-1:0] n_acc;
    logic signed [AW-1:0] scaled;
    logic                 ready_out;
    logic                 ready_row;

    // Add the lane products onto the running row sum.
    always_comb begin
        n_acc = r_acc;
        for (int l = 0; l < LANES; l++) begin
            n_acc = n_acc + AW'(i_prod[l]);
        end
    end

    assign ready_out = !r_out_valid || i_out_ready;
    assign ready_row = !r_row_valid || ready_out;
    assign o_take    = ready_row;

    // Accumulate; close the row on its final group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_row_valid <= 1'b0;
        end else if (ready_row) begin
            r_row_valid <= i_grp.valid && i_grp.end_row;
            if (i_grp.valid) begin
                r_acc <= i_grp.end_row ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_row && i_grp.valid && i_grp.end_row) begin
            r_row      <= n_acc;
            r_row_last <= i_grp.last_row;
        end
    end

    assign scaled = r_row >>> FRAC_BITS;

    // Scale, clip and hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready_out) begin
            r_out_valid <= r_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out && r_row_valid) begin
            r_out_beat.last_row <= r_row_last;
            if (scaled > SUM_MAX) begin
                r_out_beat.row_sum   <= mvdr_pkg::SUM_W'(SUM_MAX);
                r_out_beat.saturated <= 1'b1;
            end else if (scaled < SUM_MIN) begin
                r_out_beat.row_sum   <= mvdr_pkg::SUM_W'(SUM_MIN);
                r_out_beat.saturated <= 1'b1;
            end else begin
                r_out_beat.row_sum   <= scaled[mvdr_pkg::SUM_W-1:0];
                r_out_beat.saturated <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

### rtl/core/matrix_vector_dot_rows.sv
// Top level of the fixed-point matrix-vector row product.
// Load beats write LANES vector elements into LANES banks of ceil(MAX_K/LANES)
// entries (one write and one read port each); matrix beats carry LANES row
// elements that the lanes multiply against the stored vector in parallel,
// and the merge stage sums them into a 48-bit row accumulator. One beat of
// either kind is taken every clock cycle while results are taken; a row
// result passes from the beat holding the row's last group through the
// bank read, the multiplier, the accumulator and the scale/saturate
// register. The store has no reset: read only entries that were loaded.
module matrix_vector_dot_rows #(
    parameter int MAX_K     = 1024,
    parameter int LANES     = 4,
    parameter int FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  mvdr_pkg::t_in_beat                   i_in_beat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output mvdr_pkg::t_out_beat                  o_out_beat,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mvdr_pkg::PADDR_W-1:0]         paddr,
    input  logic [mvdr_pkg::APB_W-1:0]           pwdata,
    output logic [mvdr_pkg::APB_W-1:0]           prdata,
    output logic                                 pready
);

    localparam int DEPTH     = (MAX_K + LANES - 1) / LANES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW_RAW    = $clog2(MAX_K + LANES + 1);
    localparam int BW        = (BW_RAW > 13) ? BW_RAW : 13;
    localparam int USE_LANES = (LANES < mvdr_pkg::IN_LANES) ? LANES : mvdr_pkg::IN_LANES;
    localparam int RCW       = mvdr_pkg::RC_W;

    logic [mvdr_pkg::RL_W-1:0] r_row_length;
    logic [RCW-1:0]            r_row_count;
    logic [AW-1:0]             r_col_group;
    logic [RCW-1:0]            r_row_cnt;
    mvdr_pkg::t_grp_ctl        r1_ctl;
    mvdr_pkg::t_grp_ctl        r2_ctl;

    logic                      cfg_wr;
    logic [BW-1:0]             rl_ext;
    logic [BW-1:0]             k_eff;
    logic [BW-1:0]             base;
    logic [RCW-1:0]            m_eff;
    logic                      row_end;
    logic                      row_last;
    logic                      in_acc;
    logic                      is_mat;
    logic                      take;
    logic                      adv1;
    logic                      adv2;
    mvdr_pkg::t_lane_ctl       lane_ctl;
    logic signed [mvdr_pkg::PROD_W-1:0] prod [LANES];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= mvdr_pkg::RL_W'(1);
            r_row_count  <= RCW'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mvdr_pkg::REG_ROW_LENGTH: r_row_length <= pwdata[mvdr_pkg::RL_W-1:0];
                default:                  r_row_count  <= pwdata[RCW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mvdr_pkg::REG_ROW_LENGTH: prdata = mvdr_pkg::APB_W'(r_row_length);
            default:                  prdata = mvdr_pkg::APB_W'(r_row_count);
        endcase
    end

    // Clamp the row geometry and place the current group in its row.
    always_comb begin
        rl_ext = BW'(r_row_length);
        if (rl_ext == '0) begin
            k_eff = BW'(1);
        end else if (rl_ext > BW'(MAX_K)) begin
            k_eff = BW'(MAX_K);
        end else begin
            k_eff = rl_ext;
        end
        m_eff    = (r_row_count == '0) ? RCW'(1) : r_row_count;
        base     = BW'(r_col_group) * BW'(LANES);
        row_end  = !((base + BW'(LANES)) < k_eff);
        row_last = ({1'b0, r_row_cnt} + (RCW + 1)'(1)) >= {1'b0, m_eff};
    end

    // Pipeline flow: a stage moves when it is empty or the next one moves.
    assign adv2       = !r2_ctl.valid || take;
    assign adv1       = !r1_ctl.valid || adv2;
    assign o_in_ready = adv1;
    assign in_acc     = i_in_valid && adv1;
    assign is_mat     = (i_in_beat.command == mvdr_pkg::CMD_MATRIX);
    assign lane_ctl   = '{cap: adv1, mul: adv2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl      <= '0;
            r2_ctl      <= '0;
            r_col_group <= '0;
            r_row_cnt   <= '0;
        end else begin
            if (adv1) begin
                r1_ctl <= '{valid: in_acc && is_mat, end_row: row_end, last_row: row_last};
            end
            if (adv2) begin
                r2_ctl <= r1_ctl;
            end
            // Advance the column group and row counter on each matrix beat.
            if (in_acc && is_mat) begin
                if (row_end) begin
                    r_col_group <= '0;
                    r_row_cnt   <= row_last ? '0 : r_row_cnt + RCW'(1);
                end else begin
                    r_col_group <= r_col_group + AW'(1);
                end
            end
        end
    end

    // Lanes that carry data get a bank and a multiplier; the rest add nothing.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        if (l < USE_LANES) begin : g_live
            logic signed [mvdr_pkg::VAL_W-1:0] lane_val;
            logic                              wr_en;
            logic                              use_lane;

            assign lane_val = mvdr_pkg::lane_field(i_in_beat, 2'(l));
            assign wr_en    = in_acc && !is_mat &&
                              ((BW'(i_in_beat.group_index) * BW'(LANES) + BW'(l)) < BW'(MAX_K));
            assign use_lane = (base + BW'(l)) < k_eff;

            mvdr_lane #(.DEPTH(DEPTH)) u_lane (
                .i_clk     (i_clk),
                .i_ctl     (lane_ctl),
                .i_wr_en   (wr_en),
                .i_wr_addr (AW'(i_in_beat.group_index)),
                .i_wr_data (lane_val),
                .i_rd_addr (r_col_group),
                .i_mat     (lane_val),
                .i_use     (use_lane),
                .o_prod    (prod[l])
            );
        end else begin : g_idle
            assign prod[l] = '0;
        end
    end

    mvdr_merge #(.LANES(LANES), .FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prod      (prod),
        .i_grp       (r2_ctl),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_ready (i_out_ready)
    );

endmodule

### rtl/core/mvdr_checker.sv
// Port-level checks of the matrix-vector row product, bound to the top level.
module mvdr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input mvdr_pkg::t_out_beat          o_out_beat
);

    // A waiting result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A clipped result sits at one of the range limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.saturated |->
            (o_out_beat.row_sum == 32'sh7fffffff) || (o_out_beat.row_sum == 32'sh80000000))
        else $error("saturated flag without a clipped sum");

    // Input is refused only while a result waits on the consumer.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with no output back-pressure");

endmodule

bind matrix_vector_dot_rows mvdr_checker u_mvdr_checker (.*);

### tb/mvdr_row_checker.sv
// Row-sum scoreboard for the matrix-vector row product: predicts and compares result beats.
module mvdr_row_checker #(
    parameter int MAX_K     = 1024,
    parameter int LANES     = 4,
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  mvdr_pkg::t_in_beat           i_in_beat,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  mvdr_pkg::t_out_beat          i_out_beat,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [mvdr_pkg::PADDR_W-1:0] i_paddr,
    input  logic [mvdr_pkg::APB_W-1:0]   i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_rows_checked
);
    import mvdr_pkg::*;

    localparam logic signed [ACC_W-1:0] SUM_MAX = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] SUM_MIN = -48'sd2147483648;
    localparam int                      REPORT_LIMIT = 10;

    // Shadow of the block's vector store, registers and row progress
    logic signed [VAL_W-1:0] vec_mem [MAX_K];
    logic [RL_W-1:0]         len_reg;
    logic [RC_W-1:0]         cnt_reg;
    int unsigned             col_grp;
    int unsigned             row_idx;
    logic signed [ACC_W-1:0] acc;
    t_out_beat               row_sums_q [$];
    int                      fails = 0;
    int                      rows_seen = 0;

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    // Fold one accepted beat into the running row sum; queue a row sum when a row closes.
    task automatic fold_row_beat(input t_in_beat b);
        int unsigned             k;
        int unsigned             m;
        int unsigned             base;
        logic signed [VAL_W-1:0] lane_v [IN_LANES];
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] scaled;
        t_out_beat               sum_beat;
        k = (len_reg == 0) ? 1 : ((len_reg > MAX_K) ? MAX_K : len_reg);
        m = (cnt_reg == 0) ? 1 : cnt_reg;
        lane_v[0] = b.lane_value_0;
        lane_v[1] = b.lane_value_1;
        lane_v[2] = b.lane_value_2;
        lane_v[3] = b.lane_value_3;

        // Load: write the group into the store, dropping lanes past its end
        if (b.command == CMD_LOAD) begin
            base = b.group_index * LANES;
            for (int l = 0; l < LANES && l < IN_LANES; l++) begin
                if (base + l < MAX_K) begin
                    vec_mem[base + l] = lane_v[l];
                end
            end
            return;
        end

        // Matrix: accumulate lanes that fall inside the row
        base = col_grp * LANES;
        for (int l = 0; l < LANES && l < IN_LANES; l++) begin
            if (base + l < k && base + l < MAX_K) begin
                prod = lane_v[l] * vec_mem[base + l];
                acc  = acc + prod;
            end
        end
        if (base + LANES < k) begin
            col_grp++;
            return;
        end

        // Row closes: scale by floor shift, clip to 32 bits, mark the last row
        scaled             = acc >>> FRAC_BITS;
        sum_beat.saturated = 1'b0;
        if (scaled > SUM_MAX) begin
            scaled             = SUM_MAX;
            sum_beat.saturated = 1'b1;
        end else if (scaled < SUM_MIN) begin
            scaled             = SUM_MIN;
            sum_beat.saturated = 1'b1;
        end
        sum_beat.row_sum  = scaled[SUM_W-1:0];
        sum_beat.last_row = (row_idx + 1 >= m);
        row_sums_q.push_back(sum_beat);
        acc     = '0;
        col_grp = 0;
        row_idx = sum_beat.last_row ? 0 : row_idx + 1;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            len_reg = 1;
            cnt_reg = 1;
            col_grp = 0;
            row_idx = 0;
            acc     = '0;
            row_sums_q.delete();
        end else begin
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_ROW_LENGTH, 2'b00}) begin
                    len_reg = i_pwdata[RL_W-1:0];
                end else if (i_paddr == {REG_ROW_COUNT, 2'b00}) begin
                    cnt_reg = i_pwdata[RC_W-1:0];
                end
            end
            // Retire a result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                rows_seen++;
                if (row_sums_q.size() == 0) begin
                    note_failure($sformatf("unpredicted row result: sum %0d sat %0b last %0b",
                        i_out_beat.row_sum, i_out_beat.saturated, i_out_beat.last_row));
                end else begin
                    want = row_sums_q.pop_front();
                    if (i_out_beat.row_sum !== want.row_sum ||
                        i_out_beat.saturated !== want.saturated ||
                        i_out_beat.last_row !== want.last_row) begin
                        note_failure($sformatf(
                            "row result %0d: expected sum %0d sat %0b last %0b, got sum %0d sat %0b last %0b",
                            rows_seen, want.row_sum, want.saturated, want.last_row,
                            i_out_beat.row_sum, i_out_beat.saturated, i_out_beat.last_row));
                    end
                end
            end
            // Predict from the accepted input beat
            if (i_in_valid && i_in_ready) begin
                fold_row_beat(i_in_beat);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= row_sums_q.size();
        o_rows_checked <= rows_seen;
    end

endmodule

### tb/tb_matrix_vector_dot_rows.sv
// Testbench top for the matrix-vector row product: stimulus, pacing and verdict.
module tb_matrix_vector_dot_rows;
    import mvdr_pkg::*;

    localparam int MAX_K       = 1024;
    localparam int LANES       = 4;
    localparam int FRAC_BITS   = 8;
    localparam int TOTAL_BEATS = 1850;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PIPE_SETTLE = 10;
    localparam int END_SETTLE  = 20;
    localparam int LONG_HOLD   = 400;
    localparam int FILL_GROUPS = MAX_K / IN_LANES;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_beat             in_beat  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_beat            out_beat;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]     pwdata   = '0;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int rows_checked;
    int cycle_count     = 0;
    int in_idle_pct     = 0;
    int out_stall_pct   = 0;
    int load_beats      = 0;
    int matrix_beats    = 0;
    int settings_written = 0;
    bit long_hold_req   = 1'b0;

    matrix_vector_dot_rows #(
        .MAX_K     (MAX_K),
        .LANES     (LANES),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mvdr_row_checker #(
        .MAX_K     (MAX_K),
        .LANES     (LANES),
        .FRAC_BITS (FRAC_BITS)
    ) row_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_beat      (in_beat),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_beat     (out_beat),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_rows_checked (rows_checked)
    );

    always #2 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d row sums still owed", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_side
        forever begin
            if (long_hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= out_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_lane_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return r[VAL_W-1:0];
        endcase
    endfunction

    task automatic set_pace(input int idle_pct, input int stall_pct);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
    endtask

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (!in_ready);
        if (b.command == CMD_LOAD) begin
            load_beats++;
        end else begin
            matrix_beats++;
        end
    endtask

    task automatic send_load(input int grp, input logic signed [VAL_W-1:0] v0, v1, v2, v3);
        t_in_beat b;
        b.command      = CMD_LOAD;
        b.group_index  = grp[GRP_W-1:0];
        b.lane_value_0 = v0;
        b.lane_value_1 = v1;
        b.lane_value_2 = v2;
        b.lane_value_3 = v3;
        send_beat(b);
    endtask

    task automatic send_matrix(input logic signed [VAL_W-1:0] v0, v1, v2, v3);
        t_in_beat    b;
        logic [31:0] r;
        r = $urandom;
        b.command      = CMD_MATRIX;
        b.group_index  = r[GRP_W-1:0];
        b.lane_value_0 = v0;
        b.lane_value_1 = v1;
        b.lane_value_2 = v2;
        b.lane_value_3 = v3;
        send_beat(b);
    endtask

    // Drop valid and wait until every predicted row sum has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write a register once the block is idle; pause first for a row still in the pipe
    task automatic write_reg(input logic idx, input logic [APB_W-1:0] val);
        wait_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    task automatic send_random_row_group();
        send_matrix(pick_lane_value(), pick_lane_value(), pick_lane_value(), pick_lane_value());
    endtask

    task automatic send_random_load(input int grp);
        send_load(grp, pick_lane_value(), pick_lane_value(), pick_lane_value(),
                  pick_lane_value());
    endtask

    initial begin : stimulus
        int          prod;
        int          row_len;
        int          rows;
        int          groups;
        int          cut;
        int          pick;
        int          reg_val;
        bit          broken;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole store with the most negative value
        set_pace(0, 0);
        for (int g = 0; g < FILL_GROUPS; g++) begin
            send_load(g, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        end

        // Full-length rows that clip high, then low (over-range length and zero count)
        write_reg(REG_ROW_LENGTH, MAX_K);
        write_reg(REG_ROW_COUNT, 1);
        set_pace(38, 38);
        for (int g = 0; g < FILL_GROUPS; g++) begin
            send_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        end
        write_reg(REG_ROW_LENGTH, 2047);
        write_reg(REG_ROW_COUNT, 0);
        for (int g = 0; g < FILL_GROUPS; g++) begin
            send_matrix(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        end

        // Zero length acts as one column: extreme products and floor rounding
        set_pace(0, 0);
        write_reg(REG_ROW_LENGTH, 0);
        write_reg(REG_ROW_COUNT, 1);
        send_load(0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1);
        send_matrix(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_matrix(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
        send_matrix(-16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);

        // Two columns: small positive rounds to zero, small negative to minus one
        write_reg(REG_ROW_LENGTH, 2);
        send_load(0, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000);
        send_matrix(16'sd1, 16'sd0, 16'sh7FFF, 16'sh7FFF);
        send_matrix(16'sd0, 16'sd1, 16'sh8000, 16'sh8000);

        // Five columns: lanes past the row end carry data but add nothing
        write_reg(REG_ROW_LENGTH, 5);
        write_reg(REG_ROW_COUNT, 3);
        send_load(0, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
        send_load(1, 16'sd12345, 16'sh8000, 16'sh7FFF, -16'sd1);
        for (int r = 0; r < 3; r++) begin
            send_random_row_group();
            send_matrix(pick_lane_value(), 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        end

        // Lower the row count below the row already reached
        write_reg(REG_ROW_COUNT, 5);
        for (int r = 0; r < 6; r++) begin
            send_random_row_group();
        end
        write_reg(REG_ROW_COUNT, 2);
        for (int r = 0; r < 4; r++) begin
            send_random_row_group();
        end
        row_len = 5;

        // Random products, mostly short rows, with pacing that rotates by product
        prod = 0;
        while (load_beats + matrix_beats < TOTAL_BEATS) begin
            case ((prod / 5) % 4)
                0:       set_pace(0, 0);
                1:       set_pace(68, 0);
                2:       set_pace(0, 68);
                default: set_pace(38, 38);
            endcase
            if (prod == 3) begin
                // Back-pressure: one-column rows while results are held off
                write_reg(REG_ROW_LENGTH, 1);
                row_len       = 1;
                rows          = 40;
                broken        = 1'b0;
                long_hold_req = 1'b1;
            end else begin
                if ($urandom_range(9) < 8) begin
                    pick = $urandom_range(99);
                    if (pick < 4) begin
                        reg_val = 0;
                    end else if (pick < 14) begin
                        reg_val = $urandom_range(17, 64);
                    end else begin
                        reg_val = $urandom_range(1, 16);
                    end
                    write_reg(REG_ROW_LENGTH, reg_val);
                    row_len = (reg_val == 0) ? 1 : reg_val;
                end
                if ($urandom_range(9) < 6) begin
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        reg_val = 0;
                    end else if (pick == 1) begin
                        reg_val = 65535;
                    end else begin
                        reg_val = $urandom_range(1, 4);
                    end
                    write_reg(REG_ROW_COUNT, reg_val);
                end
                rows   = $urandom_range(1, 4);
                broken = ($urandom_range(9) == 0);
            end
            groups = (row_len + IN_LANES - 1) / IN_LANES;
            cut    = $urandom_range(0, groups - 1);
            for (int g = 0; g < groups; g++) begin
                send_random_load(g);
            end
            for (int r = 0; r < rows; r++) begin
                for (int g = 0; g < groups; g++) begin
                    // Cut the final row short to leave a row half done
                    if (broken && r == rows - 1 && g == cut) begin
                        break;
                    end
                    if ($urandom_range(99) < 8) begin
                        send_random_load($urandom_range(0, groups - 1));
                    end
                    send_random_row_group();
                end
            end
            prod++;
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("covered %0d vector loads and %0d matrix beats over %0d register writes",
                 load_beats, matrix_beats, settings_written);
        $display("compared %0d row sums, clipped and last-row results included", rows_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
